// File: hdl/hph_pkg.sv
// Shared types, codes and character classes of the HTTP request head parser.
package hph_pkg;

   localparam int MAX_HEADERS = 32;
   localparam logic [15:0] BUFFER_LIMIT_RESET = 16'd8192;

   // Parser phase codes.
   localparam logic [3:0] PH_START   = 4'd0;
   localparam logic [3:0] PH_METHOD  = 4'd1;
   localparam logic [3:0] PH_URI     = 4'd2;
   localparam logic [3:0] PH_VERSION = 4'd3;
   localparam logic [3:0] PH_CR      = 4'd4;
   localparam logic [3:0] PH_LF1     = 4'd5;
   localparam logic [3:0] PH_HNAME   = 4'd6;
   localparam logic [3:0] PH_HCOLON  = 4'd7;
   localparam logic [3:0] PH_HVALUE  = 4'd8;
   localparam logic [3:0] PH_LF2     = 4'd9;

   // Status codes, also used for the halted state.
   localparam logic [1:0] ST_NEED_MORE = 2'd0;
   localparam logic [1:0] ST_DONE      = 2'd1;
   localparam logic [1:0] ST_ERROR     = 2'd2;

   // Error causes.
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_TOKEN   = 3'd1;
   localparam logic [2:0] ERR_EMPTY_URI   = 3'd2;
   localparam logic [2:0] ERR_BAD_VERSION = 3'd3;
   localparam logic [2:0] ERR_NO_LF       = 3'd4;
   localparam logic [2:0] ERR_BAD_VALUE   = 3'd5;
   localparam logic [2:0] ERR_BUFFER_FULL = 3'd6;
   localparam logic [2:0] ERR_TOO_MANY    = 3'd7;

   // Field kinds.
   localparam logic [2:0] FK_NONE    = 3'd0;
   localparam logic [2:0] FK_METHOD  = 3'd1;
   localparam logic [2:0] FK_URI     = 3'd2;
   localparam logic [2:0] FK_VERSION = 3'd3;
   localparam logic [2:0] FK_HNAME   = 3'd4;
   localparam logic [2:0] FK_HVALUE  = 3'd5;

   // Characters.
   localparam logic [7:0] CH_HT    = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   typedef struct packed {
      logic [3:0]  phase;
      logic [15:0] position;
      logic [15:0] token_start;
      logic [3:0]  version_index;
      logic        version_bad;
      logic [3:0]  major_digit;
      logic [3:0]  minor_digit;
      logic [15:0] last_nonblank;
      logic [5:0]  header_total;
      logic [1:0]  halted;
      logic [2:0]  cause;
   } state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  error_cause;
      logic [2:0]  field_kind;
      logic [15:0] field_begin;
      logic [15:0] field_end;
      logic [5:0]  header_index;
      logic [3:0]  version_major;
      logic [3:0]  version_minor;
      logic [15:0] byte_offset;
   } result_type;

   localparam state_type STATE_CLEAR = '{
      phase: PH_START, position: 16'd0, token_start: 16'd0, version_index: 4'd0,
      version_bad: 1'b0, major_digit: 4'd0, minor_digit: 4'd0,
      last_nonblank: 16'd0, header_total: 6'd0, halted: ST_NEED_MORE,
      cause: ERR_NONE};

   // Token character: digits, letters and the RFC punctuation set, plus the slash.
   function automatic logic is_tchar(input logic [7:0] c);
      logic hit;
      hit = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A) ||
            c == 8'h21 || c == 8'h23 || c == 8'h24 || c == 8'h25 ||
            c == 8'h26 || c == 8'h27 || c == 8'h2A || c == 8'h2B ||
            c == 8'h2D || c == 8'h2E || c == 8'h2F || c == 8'h5E ||
            c == 8'h5F || c == 8'h60 || c == 8'h7C || c == 8'h7E;
      return hit;
   endfunction

endpackage

// File: hdl/hph_step.sv
// Next-state and result logic of the parser for one request byte.
module hph_step (
   input  logic [7:0]          data_byte,
   input  logic                restart,
   input  logic [15:0]         buffer_limit,
   input  hph_pkg::state_type  state_q,
   output hph_pkg::state_type  state_d,
   output hph_pkg::result_type result
);

   hph_pkg::state_type cur;
   logic [15:0] pos;
   logic [2:0]  err;
   logic        done;
   logic        tok;
   logic        skip;
   logic [15:0] val_start;
   logic [15:0] val_last;

   always_comb begin
      cur       = restart ? hph_pkg::STATE_CLEAR : state_q;
      state_d   = cur;
      result    = '0;
      err       = hph_pkg::ERR_NONE;
      done      = 1'b0;
      skip      = 1'b0;
      pos       = cur.position;
      tok       = hph_pkg::is_tchar(data_byte);
      val_start = cur.token_start;
      val_last  = cur.last_nonblank;
      result.byte_offset = pos;

      if (cur.halted != hph_pkg::ST_NEED_MORE) begin
         result.status      = cur.halted;
         result.error_cause = cur.cause;
      end else begin
         if (pos >= buffer_limit) begin
            err = hph_pkg::ERR_BUFFER_FULL;
         end else begin
            unique case (cur.phase)
               hph_pkg::PH_START: begin
                  if (data_byte != hph_pkg::CH_CR && data_byte != hph_pkg::CH_LF) begin
                     if (!tok) begin
                        err = hph_pkg::ERR_BAD_TOKEN;
                     end else begin
                        state_d.token_start = pos;
                        state_d.phase       = hph_pkg::PH_METHOD;
                     end
                  end
               end
               hph_pkg::PH_METHOD: begin
                  if (data_byte == hph_pkg::CH_SP) begin
                     result.field_kind   = hph_pkg::FK_METHOD;
                     result.field_begin  = cur.token_start;
                     result.field_end    = pos - 16'd1;
                     state_d.token_start = pos + 16'd1;
                     state_d.phase       = hph_pkg::PH_URI;
                  end else if (!tok) begin
                     err = hph_pkg::ERR_BAD_TOKEN;
                  end
               end
               hph_pkg::PH_URI: begin
                  if (data_byte == hph_pkg::CH_SP) begin
                     if (pos == cur.token_start) begin
                        err = hph_pkg::ERR_EMPTY_URI;
                     end else begin
                        result.field_kind     = hph_pkg::FK_URI;
                        result.field_begin    = cur.token_start;
                        result.field_end      = pos - 16'd1;
                        state_d.token_start   = pos + 16'd1;
                        state_d.version_index = 4'd0;
                        state_d.version_bad   = 1'b0;
                        state_d.phase         = hph_pkg::PH_VERSION;
                     end
                  end else if (!tok) begin
                     err = hph_pkg::ERR_BAD_TOKEN;
                  end
               end
               hph_pkg::PH_VERSION: begin
                  if (data_byte == hph_pkg::CH_SP || data_byte == hph_pkg::CH_CR ||
                      data_byte == hph_pkg::CH_LF) begin
                     if (cur.version_index != 4'd8 || cur.version_bad) begin
                        err = hph_pkg::ERR_BAD_VERSION;
                     end else begin
                        result.field_kind    = hph_pkg::FK_VERSION;
                        result.field_begin   = cur.token_start;
                        result.field_end     = pos - 16'd1;
                        result.version_major = cur.major_digit;
                        result.version_minor = cur.minor_digit;
                        state_d.phase = (data_byte == hph_pkg::CH_CR) ?
                                        hph_pkg::PH_CR : hph_pkg::PH_LF1;
                     end
                  end else begin
                     // The literal "HTTP/d.d" is checked one position per byte.
                     unique case (cur.version_index)
                        4'd0: if (data_byte != hph_pkg::CH_H) state_d.version_bad = 1'b1;
                        4'd1, 4'd2: begin
                           if (data_byte != hph_pkg::CH_T) state_d.version_bad = 1'b1;
                        end
                        4'd3: if (data_byte != hph_pkg::CH_P) state_d.version_bad = 1'b1;
                        4'd4: if (data_byte != hph_pkg::CH_SLASH) state_d.version_bad = 1'b1;
                        4'd5: begin
                           if (data_byte >= hph_pkg::CH_0 && data_byte <= hph_pkg::CH_9) begin
                              state_d.major_digit = 4'(data_byte - hph_pkg::CH_0);
                           end else begin
                              state_d.version_bad = 1'b1;
                           end
                        end
                        4'd6: if (data_byte != hph_pkg::CH_DOT) state_d.version_bad = 1'b1;
                        4'd7: begin
                           if (data_byte >= hph_pkg::CH_0 && data_byte <= hph_pkg::CH_9) begin
                              state_d.minor_digit = 4'(data_byte - hph_pkg::CH_0);
                           end else begin
                              state_d.version_bad = 1'b1;
                           end
                        end
                        default: state_d.version_bad = 1'b1;
                     endcase
                     if (cur.version_index < 4'd9) begin
                        state_d.version_index = cur.version_index + 4'd1;
                     end
                  end
               end
               hph_pkg::PH_CR: begin
                  if (data_byte != hph_pkg::CH_LF) err = hph_pkg::ERR_NO_LF;
                  else state_d.phase = hph_pkg::PH_LF1;
               end
               hph_pkg::PH_LF1: begin
                  if (data_byte == hph_pkg::CH_CR) begin
                     state_d.phase = hph_pkg::PH_LF2;
                  end else if (data_byte == hph_pkg::CH_LF) begin
                     done = 1'b1;
                  end else if (!tok) begin
                     err = hph_pkg::ERR_BAD_TOKEN;
                  end else if (cur.header_total >= 6'(hph_pkg::MAX_HEADERS)) begin
                     err = hph_pkg::ERR_TOO_MANY;
                  end else begin
                     state_d.token_start = pos;
                     state_d.phase       = hph_pkg::PH_HNAME;
                  end
               end
               hph_pkg::PH_HNAME: begin
                  if (data_byte == hph_pkg::CH_COLON) begin
                     result.field_kind   = hph_pkg::FK_HNAME;
                     result.field_begin  = cur.token_start;
                     result.field_end    = pos - 16'd1;
                     result.header_index = cur.header_total;
                     state_d.phase       = hph_pkg::PH_HCOLON;
                  end else if (!tok) begin
                     err = hph_pkg::ERR_BAD_TOKEN;
                  end
               end
               hph_pkg::PH_HCOLON, hph_pkg::PH_HVALUE: begin
                  // Blanks right after the colon are skipped; the first other byte
                  // opens the value.
                  if (cur.phase == hph_pkg::PH_HCOLON) begin
                     if (data_byte == hph_pkg::CH_SP || data_byte == hph_pkg::CH_HT) begin
                        skip = 1'b1;
                     end else begin
                        val_start             = pos;
                        val_last              = pos - 16'd1;
                        state_d.token_start   = val_start;
                        state_d.last_nonblank = val_last;
                        state_d.phase         = hph_pkg::PH_HVALUE;
                     end
                  end
                  if (!skip) begin
                     if (data_byte == hph_pkg::CH_CR || data_byte == hph_pkg::CH_LF) begin
                        result.field_kind    = hph_pkg::FK_HVALUE;
                        result.field_begin   = val_start;
                        result.field_end     = val_last;
                        result.header_index  = cur.header_total;
                        state_d.header_total = cur.header_total + 6'd1;
                        state_d.phase = (data_byte == hph_pkg::CH_CR) ?
                                        hph_pkg::PH_CR : hph_pkg::PH_LF1;
                     end else if ((data_byte < hph_pkg::CH_SP && data_byte != hph_pkg::CH_HT) ||
                                  data_byte >= hph_pkg::CH_DEL) begin
                        err = hph_pkg::ERR_BAD_VALUE;
                     end else if (data_byte != hph_pkg::CH_SP && data_byte != hph_pkg::CH_HT) begin
                        state_d.last_nonblank = pos;
                     end
                  end
               end
               hph_pkg::PH_LF2: begin
                  if (data_byte != hph_pkg::CH_LF) err = hph_pkg::ERR_BAD_TOKEN;
                  else done = 1'b1;
               end
               default: err = hph_pkg::ERR_BAD_TOKEN;
            endcase
         end

         if (err != hph_pkg::ERR_NONE) begin
            result             = '0;
            result.status      = hph_pkg::ST_ERROR;
            result.error_cause = err;
            result.byte_offset = pos;
            state_d.halted     = hph_pkg::ST_ERROR;
            state_d.cause      = err;
         end else if (done) begin
            result.status  = hph_pkg::ST_DONE;
            state_d.halted = hph_pkg::ST_DONE;
         end else begin
            state_d.position = pos + 16'd1;
         end
      end
   end

endmodule

// File: hdl/http_request_head_parser.sv
// Path: a request byte waits in the input register, then is parsed into the result register,
// which holds a stalled response until it is taken. Throughput: one request byte per cycle
// while responses are taken; an empty input register still refills while a response waits.
// The parser state and the result register are updated by one pass of hph_step per byte.
// Reset (synchronous, active high) clears the parser state and both valid flags, and
// sets buffer_limit to 8192; the configuration port is always ready.
module http_request_head_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_error_cause,
   output logic [2:0]  rsp_field_kind,
   output logic [15:0] rsp_field_begin,
   output logic [15:0] rsp_field_end,
   output logic [5:0]  rsp_header_index,
   output logic [3:0]  rsp_version_major,
   output logic [3:0]  rsp_version_minor,
   output logic [15:0] rsp_byte_offset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_buffer_limit
);

   // Input register: one request byte waiting for the parse step.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_restart_ff;

   // Parser state and the result register.
   hph_pkg::state_type  state_ff, state_in;
   hph_pkg::result_type result_ff, result_in;
   logic                out_valid_ff, out_valid_in;
   logic [15:0]         limit_ff;

   logic out_free;
   logic step_fire;
   logic req_fire;

   // The result register can take a new value when it is empty or being drained
   // this cycle; the input register frees up exactly when its byte moves on.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step_fire = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   hph_step u_step (
      .data_byte    (in_byte_ff),
      .restart      (in_restart_ff),
      .buffer_limit (limit_ff),
      .state_q      (state_ff),
      .state_d      (state_in),
      .result       (result_in)
   );

   always_comb begin
      in_valid_in = req_fire ? 1'b1 : (step_fire ? 1'b0 : in_valid_ff);
      out_valid_in = step_fire ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   // Control state and the configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= hph_pkg::STATE_CLEAR;
         limit_ff     <= hph_pkg::BUFFER_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_fire) begin
            state_ff <= state_in;
         end
         if (csr_valid) begin
            limit_ff <= csr_buffer_limit;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff    <= req_data_byte;
         in_restart_ff <= req_restart;
      end
      if (step_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = result_ff.status;
   assign rsp_error_cause   = result_ff.error_cause;
   assign rsp_field_kind    = result_ff.field_kind;
   assign rsp_field_begin   = result_ff.field_begin;
   assign rsp_field_end     = result_ff.field_end;
   assign rsp_header_index  = result_ff.header_index;
   assign rsp_version_major = result_ff.version_major;
   assign rsp_version_minor = result_ff.version_minor;
   assign rsp_byte_offset   = result_ff.byte_offset;

endmodule

// File: hdl/hph_checker.sv
// Port-level assertions for the HTTP request head parser and their bind.
module hph_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [2:0]  rsp_error_cause,
   input logic [2:0]  rsp_field_kind,
   input logic [3:0]  rsp_version_major,
   input logic [3:0]  rsp_version_minor,
   input logic [15:0] rsp_byte_offset
);

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_byte_offset) && $stable(rsp_field_kind))
      else $error("response changed while stalled");

   // An error response carries a cause and reports no field.
   a_err_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == hph_pkg::ST_ERROR |->
      rsp_error_cause != hph_pkg::ERR_NONE && rsp_field_kind == hph_pkg::FK_NONE)
      else $error("error response without cause or with a field");

   // Non-error responses carry no cause.
   a_no_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != hph_pkg::ST_ERROR |->
      rsp_error_cause == hph_pkg::ERR_NONE)
      else $error("cause reported without error");

   // A field is only reported while the head is still being parsed.
   a_field_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_kind != hph_pkg::FK_NONE |->
      rsp_status == hph_pkg::ST_NEED_MORE)
      else $error("field reported after halting");

   // Version digits are decimal.
   a_version_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_kind == hph_pkg::FK_VERSION |->
      rsp_version_major <= 4'd9 && rsp_version_minor <= 4'd9)
      else $error("version digit out of range");

endmodule

bind http_request_head_parser hph_checker u_hph_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_error_cause   (rsp_error_cause),
   .rsp_field_kind    (rsp_field_kind),
   .rsp_version_major (rsp_version_major),
   .rsp_version_minor (rsp_version_minor),
   .rsp_byte_offset   (rsp_byte_offset)
);
